// ===== rtl/htx_pkg.sv =====
// Shared types, constants and character helpers for the HTML text extractor.
// Used by htx_tag, htx_entity and html_text_extractor; depends on nothing.

package htx_pkg;

   // Tag name buffer: letters stored while tag_count + 1 < TAG_BUF.
   localparam int TAG_BUF    = 16;
   // Entity buffer: characters stored while entity_count < ENTITY_BUF.
   localparam int ENTITY_BUF = 12;

   localparam int TAG_CNT_W  = $clog2(TAG_BUF);
   localparam int ENT_CNT_W  = $clog2(ENTITY_BUF + 1);

   // Longest name ever compared is "/noscript", so only that many tag letters are kept.
   localparam int NAME_MAX   = 9;
   localparam int TAG_KEEP   = NAME_MAX;
   // Longest named entity is four letters; numeric parsing is tracked on the fly.
   localparam int ENT_KEEP   = 4;

   localparam logic [15:0] CAP_RESET = 16'd256;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NBSP  = 8'hA0;

   // One input beat as seen by the processing logic.
   typedef struct packed {
      logic       go;
      logic       finish;
      logic [7:0] data;
   } step_type;

   // What the tag tracker hands to the text path.
   typedef struct packed {
      logic text_push;
      logic space_push;
   } tag_route_type;

   // A byte offered to the next stage of the text path.
   typedef struct packed {
      logic       en;
      logic [7:0] chr;
   } txt_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // Compares the first n stored characters with a right-justified string of len chars.
   function automatic logic same_name(input logic [NAME_MAX-1:0][7:0] t, input int n,
                                      input logic [8*NAME_MAX-1:0] s, input int len);
      logic ok;
      ok = (n == len);
      for (int i = 0; i < NAME_MAX; i++) begin
         if (i < len && t[i] != 8'(s >> (8 * (len - 1 - i)))) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

// ===== rtl/htx_tag.sv =====
// Tag tracker: collects the lowercased tag name, handles suppression of
// script/style/noscript text and routes bytes to the text path. Uses htx_pkg.

module htx_tag (
   input  logic                   clock,
   input  logic                   reset,
   input  htx_pkg::step_type      step,
   output htx_pkg::tag_route_type route
);
   import htx_pkg::*;

   logic                       inside_ff, inside_in;
   logic                       ended_ff, ended_in;
   logic                       supp_ff, supp_in;
   logic [TAG_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TAG_KEEP-1:0][7:0]   chr_ff, chr_in;

   logic [7:0] b;
   logic       sup_on, sup_off, spacey;
   int         n;

   assign b = step.data;
   assign n = int'(cnt_ff);

   // Classify the collected name at the closing bracket.
   always_comb begin
      sup_on  = same_name(chr_ff, n, "script", 6) || same_name(chr_ff, n, "style", 5) ||
                same_name(chr_ff, n, "noscript", 8);
      sup_off = same_name(chr_ff, n, "/script", 7) || same_name(chr_ff, n, "/style", 6) ||
                same_name(chr_ff, n, "/noscript", 9);
      spacey  = (n > 0 && chr_ff[0] == CH_SLASH) || same_name(chr_ff, n, "br", 2) ||
                same_name(chr_ff, n, "p", 1) || same_name(chr_ff, n, "li", 2);
   end

   // Per-beat state update and routing.
   always_comb begin
      inside_in        = inside_ff;
      ended_in         = ended_ff;
      supp_in          = supp_ff;
      cnt_in           = cnt_ff;
      chr_in           = chr_ff;
      route.text_push  = 1'b0;
      route.space_push = 1'b0;
      if (step.go && !step.finish) begin
         if (inside_ff) begin
            if (b == CH_GT) begin
               inside_in = 1'b0;
               cnt_in    = '0;
               if (sup_on) begin
                  supp_in = 1'b1;
               end else if (sup_off) begin
                  supp_in = 1'b0;
               end else if (!supp_ff && spacey) begin
                  route.space_push = 1'b1;
               end
            end else if (is_ws(b)) begin
               ended_in = 1'b1;
            end else if (!ended_ff && n < TAG_BUF - 1 &&
                         (is_letter(b) || (b == CH_SLASH && n == 0))) begin
               for (int i = 0; i < TAG_KEEP; i++) begin
                  if (n == i) chr_in[i] = is_letter(b) ? (b | 8'h20) : b;
               end
               cnt_in = cnt_ff + TAG_CNT_W'(1);
            end
         end else if (b == CH_LT) begin
            inside_in = 1'b1;
            cnt_in    = '0;
            ended_in  = 1'b0;
         end else if (!supp_ff) begin
            route.text_push = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         ended_ff  <= 1'b0;
         supp_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         inside_ff <= inside_in;
         ended_ff  <= ended_in;
         supp_ff   <= supp_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Name characters are read only below the count, so they need no reset.
   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
   end

endmodule

// ===== rtl/htx_entity.sv =====
// Entity decoder: tracks an open character reference, decodes named and
// numeric forms at the semicolon and passes other bytes on. Uses htx_pkg.

module htx_entity (
   input  logic              clock,
   input  logic              reset,
   input  htx_pkg::step_type step,
   input  htx_pkg::txt_type  push,
   output htx_pkg::txt_type  txt
);
   import htx_pkg::*;

   // Wrapping numeric accumulator with a sticky overflow flag; only values below 256 can ever emit.
   typedef struct packed {
      logic [7:0] acc;
      logic       big;
      logic       stop;
   } num_type;

   logic [ENT_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ENT_KEEP-1:0][7:0] chr_ff, chr_in;
   num_type                  num_a_ff, num_a_in;
   num_type                  num_b_ff, num_b_in;
   logic                     z2_ff, z2_in;
   logic                     x3_ff, x3_in;
   logic                     pfx_ff, pfx_in;

   logic [7:0]               v;
   logic [ENT_CNT_W-1:0]     pos;
   int                       n;
   logic [NAME_MAX-1:0][7:0] name;
   logic                     hex_mode;
   num_type                  sel;
   logic                     dec_en;
   logic [7:0]               dec_chr;

   function automatic logic is_x(input logic [7:0] c);
      return c == 8'h78 || c == 8'h58;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic num_type num_step(input num_type s, input logic hex,
                                        input logic [7:0] c);
      num_type     r;
      logic        ok;
      logic [3:0]  d;
      logic [11:0] nxt;
      r   = s;
      ok  = hex ? is_hex(c) : is_digit(c);
      d   = is_digit(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
      nxt = hex ? ({s.acc, 4'h0} + 12'(d))
                : (12'({s.acc, 3'b000}) + 12'({s.acc, 1'b0}) + 12'(d));
      if (!s.stop) begin
         if (!ok) begin
            r.stop = 1'b1;
         end else begin
            r.acc = nxt[7:0];
            r.big = s.big | (nxt[11:8] != 4'h0);
         end
      end
      return r;
   endfunction

   assign v        = push.chr;
   assign pos      = cnt_ff - ENT_CNT_W'(1);
   assign n        = int'(pos);
   assign hex_mode = is_x(chr_ff[1]);

   // Decode of the closed reference.
   always_comb begin
      name = '0;
      for (int i = 0; i < ENT_KEEP; i++) name[i] = chr_ff[i];
      sel     = (n >= 2 && hex_mode && pfx_ff) ? num_b_ff : num_a_ff;
      dec_en  = 1'b0;
      dec_chr = CH_SPACE;
      if (same_name(name, n, "amp", 3)) begin
         dec_en  = 1'b1;
         dec_chr = CH_AMP;
      end else if (same_name(name, n, "lt", 2)) begin
         dec_en  = 1'b1;
         dec_chr = CH_LT;
      end else if (same_name(name, n, "gt", 2)) begin
         dec_en  = 1'b1;
         dec_chr = CH_GT;
      end else if (same_name(name, n, "quot", 4)) begin
         dec_en  = 1'b1;
         dec_chr = CH_QUOT;
      end else if (same_name(name, n, "apos", 4)) begin
         dec_en  = 1'b1;
         dec_chr = CH_APOS;
      end else if (same_name(name, n, "nbsp", 4)) begin
         dec_en  = 1'b1;
         dec_chr = CH_SPACE;
      end else if (n >= 1 && chr_ff[0] == CH_HASH && !sel.big) begin
         if (sel.acc != 8'h00 && !sel.acc[7]) begin
            dec_en  = 1'b1;
            dec_chr = sel.acc;
         end else if (sel.acc == CH_NBSP) begin
            dec_en  = 1'b1;
            dec_chr = CH_SPACE;
         end
      end
   end

   // Per-beat update of the open reference.
   always_comb begin
      cnt_in   = cnt_ff;
      chr_in   = chr_ff;
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      z2_in    = z2_ff;
      x3_in    = x3_ff;
      pfx_in   = pfx_ff;
      txt.en   = 1'b0;
      txt.chr  = v;
      if (step.go) begin
         if (step.finish) begin
            cnt_in = '0;
         end else if (push.en) begin
            if (cnt_ff != '0) begin
               if (v == CH_SEMI) begin
                  cnt_in  = '0;
                  txt.en  = dec_en;
                  txt.chr = dec_chr;
               end else if (int'(cnt_ff) < ENTITY_BUF &&
                            (is_letter(v) || is_digit(v) || v == CH_HASH)) begin
                  for (int i = 0; i < ENT_KEEP; i++) begin
                     if (n == i) chr_in[i] = v;
                  end
                  // Decimal digits start right after '#', hex after "#x".
                  if (n == 1 && !is_x(v)) num_a_in = num_step(num_a_ff, 1'b0, v);
                  if (n >= 2) num_a_in = num_step(num_a_ff, hex_mode, v);
                  // A second "0x" after "#x" restarts the hex value at the fifth char.
                  if (n == 2) z2_in = (v == CH_ZERO);
                  if (n == 3) x3_in = is_x(v);
                  if (n == 4) pfx_in = z2_ff && x3_ff && is_hex(v);
                  if (n >= 4 && hex_mode) num_b_in = num_step(num_b_ff, 1'b1, v);
                  cnt_in = cnt_ff + ENT_CNT_W'(1);
               end else begin
                  cnt_in = '0;
                  txt.en = 1'b1;
               end
            end else if (v == CH_AMP) begin
               cnt_in   = ENT_CNT_W'(1);
               num_a_in = '0;
               num_b_in = '0;
               pfx_in   = 1'b0;
            end else begin
               txt.en = 1'b1;
            end
         end
      end
   end

   // Open/closed state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Reference contents; the accumulators and prefix flag are cleared when a reference opens.
   always_ff @(posedge clock) begin
      chr_ff   <= chr_in;
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      z2_ff    <= z2_in;
      x3_ff    <= x3_in;
      pfx_ff   <= pfx_in;
   end

endmodule

// ===== rtl/html_text_extractor.sv =====
// Top level of the HTML text extractor: input register, text emitter and
// result register. Instantiates htx_tag and htx_entity; uses htx_pkg.

// Each accepted req beat (a raw HTML byte, or a finish command) yields one or
// two rsp beats; the last one carries rsp_last. A beat that emits nothing shows
// rsp_char_valid low. When a collapsed space and a text byte are both emitted,
// the space comes first and the result register holds the second beat in a
// second slot, so the input side pauses until that beat has left. Otherwise
// one beat is taken every cycle while rsp_stall is low, and an accepted req
// beat passes the input register, then the result register, to its first rsp
// beat. rsp_room_left reports whether emitted length plus one is still below
// csr capacity after the step. csr_wr_data sets the capacity (reset value 256)
// and must only be written while no beat is in flight.

module html_text_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_room_left,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import htx_pkg::*;

   logic        in_valid_ff;
   logic        in_type_ff;
   logic [7:0]  in_byte_ff;

   logic [15:0] cap_ff;
   logic [15:0] len_ff, len_in;
   logic        pend_ff, pend_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_cv_ff, out_cv_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_room_ff, out_room_in;
   logic        out_last_ff, out_last_in;
   logic        sec_valid_ff, sec_valid_in;
   logic [7:0]  sec_char_ff, sec_char_in;

   logic          out_free;
   step_type      step;
   tag_route_type route;
   txt_type       push;
   txt_type       txt;
   logic [17:0]   len_x;
   logic          room0, room1, room2;
   logic          e1, e2;

   // The output side is free when it is empty or its last beat leaves now.
   assign out_free  = !out_valid_ff || (!rsp_stall && !sec_valid_ff);
   assign req_stall = in_valid_ff && !out_free;

   assign step.go     = in_valid_ff && out_free;
   assign step.finish = in_type_ff;
   assign step.data   = in_byte_ff;

   htx_tag u_tag (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .route (route)
   );

   assign push.en  = route.text_push | route.space_push;
   assign push.chr = route.space_push ? CH_SPACE : in_byte_ff;

   htx_entity u_entity (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .push  (push),
      .txt   (txt)
   );

   // Capacity checks for zero, one or two more emitted bytes.
   assign len_x = {2'b00, len_ff};
   assign room0 = (len_x + 18'd1) < {2'b00, cap_ff};
   assign room1 = (len_x + 18'd2) < {2'b00, cap_ff};
   assign room2 = (len_x + 18'd3) < {2'b00, cap_ff};

   // Whitespace collapse and emission.
   always_comb begin
      len_in  = len_ff;
      pend_in = pend_ff;
      e1      = 1'b0;
      e2      = 1'b0;
      if (step.go) begin
         if (step.finish) begin
            pend_in = 1'b0;
         end else if (txt.en) begin
            if (is_ws(txt.chr)) begin
               pend_in = (len_ff != 16'd0);
            end else begin
               e1      = pend_ff && room0;
               e2      = e1 ? room1 : room0;
               len_in  = len_ff + 16'(e1) + 16'(e2);
               pend_in = 1'b0;
            end
         end
      end
   end

   // Result register with a second slot for the byte after a space.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_cv_in    = out_cv_ff;
      out_char_in  = out_char_ff;
      out_room_in  = out_room_ff;
      out_last_in  = out_last_ff;
      sec_valid_in = sec_valid_ff;
      sec_char_in  = sec_char_ff;
      if (step.go) begin
         out_valid_in = 1'b1;
         out_cv_in    = e1 | e2;
         out_char_in  = e1 ? CH_SPACE : (e2 ? txt.chr : 8'h00);
         out_room_in  = (e1 && e2) ? room2 : ((e1 || e2) ? room1 : room0);
         out_last_in  = !(e1 && e2);
         sec_valid_in = e1 && e2;
         sec_char_in  = txt.chr;
      end else if (out_valid_ff && !rsp_stall) begin
         if (sec_valid_ff) begin
            out_cv_in    = 1'b1;
            out_char_in  = sec_char_ff;
            out_last_in  = 1'b1;
            sec_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_in_byte;
      end
      out_cv_ff   <= out_cv_in;
      out_char_ff <= out_char_in;
      out_room_ff <= out_room_in;
      out_last_ff <= out_last_in;
      sec_char_ff <= sec_char_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_valid = out_cv_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_room_left  = out_room_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== rtl/htx_checker.sv =====
// Port-level checks for the HTML text extractor result channel.
// Bound to html_text_extractor; needs no package.

module htx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_char_valid,
   input logic [7:0]  rsp_out_char,
   input logic        rsp_room_left,
   input logic        rsp_last
);

   // A beat without a character is the only beat of its step and carries zero.
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_out_char == 8'h00 && rsp_last)
      else $error("empty result beat is not a lone zero beat");

   // The first of two beats is always the collapsed space.
   a_first_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_valid && rsp_out_char == 8'h20)
      else $error("first of two beats is not a space");

   // The second beat follows at once, closes the step and keeps the room flag.
   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_char_valid && rsp_last && $stable(rsp_room_left))
      else $error("second beat missing or inconsistent");

   // A stalled beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
         $stable(rsp_char_valid) && $stable(rsp_last) && $stable(rsp_room_left))
      else $error("stalled result beat changed");

endmodule

bind html_text_extractor htx_checker u_htx_checker (.*);
